[design/field_centric_drive_mixer_top_macros.svh]
// ----------------------------------------------------------------------------
// field_centric_drive_mixer_top_macros.svh
// Assertion macros for the field-centric drive mixer. The simulation forms
// check on clk with rst_n as the disable; synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef FIELD_CENTRIC_DRIVE_MIXER_TOP_MACROS_SVH
`define FIELD_CENTRIC_DRIVE_MIXER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CFDM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfdm: implication check failed");

// implication after a fixed number of cycles
`define CFDM_ASSERT_AFTER(lbl, n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("cfdm: delayed check failed");

`else

`define CFDM_ASSERT_IMPLY(lbl, ante, cons)
`define CFDM_ASSERT_AFTER(lbl, n, ante, cons)

`endif

`endif

[design/cfdm_pkg.sv]
// ----------------------------------------------------------------------------
// cfdm_pkg
// Shared widths, stage types and elaboration-time table builders for the
// field-centric drive mixer.
// ----------------------------------------------------------------------------
package cfdm_pkg;

  // trig table geometry
  localparam int TRIG_TABLE_DEPTH = 1024;
  localparam int TRIG_FRAC_BITS   = 14;
  localparam int TRIG_DEPTH_LOG2  = $clog2(TRIG_TABLE_DEPTH);

  // field widths
  localparam int STICK_W   = 8;
  localparam int HEAD_W    = 16;
  localparam int QUAD_R_W  = 14;
  localparam int CMD_W     = 8;
  localparam int CMD_LIMIT = 127;

  // shaped stick: magnitude up to 129, signed needs 9 bits
  localparam int CURVE_MAG_W = 8;
  localparam int CURVE_W     = CURVE_MAG_W + 1;
  localparam int CURVE_TAB_N = 2 ** STICK_W;

  // trig table: entries 0..DEPTH inclusive, top entry is 1.0
  localparam int IDX_W      = $clog2(TRIG_TABLE_DEPTH + 1);
  localparam int TRIG_MAG_W = TRIG_FRAC_BITS + 1;
  localparam int TRIG_W     = TRIG_FRAC_BITS + 2;

  // mixing
  localparam int PROD_W = CURVE_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 2;

  // Q30 angle constants for the table builder
  localparam longint unsigned PIO2_Q30 = 64'h6487ED51;
  localparam int              Q30_BITS = 30;

  // front stage word
  typedef struct packed {
    logic                       valid;
    logic signed [CURVE_W-1:0]  x;
    logic signed [CURVE_W-1:0]  y;
    logic signed [CURVE_W-1:0]  turn;
    logic [IDX_W-1:0]           idx_s;
    logic [IDX_W-1:0]           idx_c;
    logic                       neg_s;
    logic                       neg_c;
  } cfdm_front_t;

  // result word
  typedef struct packed {
    logic                     valid;
    logic signed [CMD_W-1:0]  left;
    logic signed [CMD_W-1:0]  right;
    logic signed [CMD_W-1:0]  strafe;
  } cfdm_cmd_t;

  // Power-1.5 curve magnitude: largest k with 127*(2k-1)^2 <= 4*m^3.
  // Only evaluated at elaboration to fill the curve table.
  function automatic logic [CURVE_MAG_W-1:0] curve_mag(input int unsigned m);
    longint unsigned lim;
    longint unsigned k;
    lim = 64'd4 * longint'(m) * longint'(m) * longint'(m);
    k = 64'd0;
    while (64'd127 * (64'd2 * k + 64'd1) * (64'd2 * k + 64'd1) <= lim)
      k = k + 64'd1;
    return k[CURVE_MAG_W-1:0];
  endfunction

  // Unsigned quotient by shift and subtract, for the table builder.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine entry in Q(TRIG_FRAC_BITS), Taylor series in Q30.
  // Only evaluated at elaboration to fill the trig table.
  function automatic logic [TRIG_MAG_W-1:0] quarter_sine(input int unsigned i);
    longint unsigned a;
    longint unsigned t;
    longint unsigned k;
    longint unsigned rnd;
    longint          sum;
    bit              neg;
    a   = (PIO2_Q30 * longint'(i)) >> TRIG_DEPTH_LOG2;
    t   = a;
    sum = longint'(a);
    k   = 64'd1;
    neg = 1'b1;
    while (t != 64'd0 && k < 64'd40) begin
      t = (((t * a) >> Q30_BITS) * a) >> Q30_BITS;
      t = udiv64(t, (64'd2 * k) * (64'd2 * k + 64'd1));
      if (neg) sum = sum - longint'(t);
      else     sum = sum + longint'(t);
      neg = !neg;
      k = k + 64'd1;
    end
    if (sum < 0) sum = 0;
    rnd = (longint'(sum) + (64'd1 << (Q30_BITS - TRIG_FRAC_BITS - 1)))
          >> (Q30_BITS - TRIG_FRAC_BITS);
    return rnd[TRIG_MAG_W-1:0];
  endfunction

endpackage

[design/cfdm_front.sv]
// ----------------------------------------------------------------------------
// cfdm_front
// First stage: shapes the three stick values through the power-1.5 curve
// table and turns the heading into sine and cosine table addresses.
// ----------------------------------------------------------------------------
module cfdm_front import cfdm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic signed [STICK_W-1:0]  stick_x,
  input  logic signed [STICK_W-1:0]  stick_y,
  input  logic signed [STICK_W-1:0]  stick_turn,
  input  logic [HEAD_W-1:0]          heading,
  output cfdm_front_t                front_o
);

  localparam int IPROD_W = QUAD_R_W + IDX_W;

  // curve magnitude table, indexed by |stick|
  logic [CURVE_MAG_W-1:0] curve_lut [CURVE_TAB_N];

  for (genvar m = 0; m < CURVE_TAB_N; m++) begin : g_curve
    localparam logic [CURVE_MAG_W-1:0] CURVE_VAL = curve_mag(m);
    assign curve_lut[m] = CURVE_VAL;
  end

  cfdm_front_t front_r, front_nxt;

  logic [1:0]          quad_s, quad_c;
  logic [IPROD_W-1:0]  iprod;
  logic [IDX_W-1:0]    idx;

  // magnitude of an 8-bit signed value; -128 maps to 128
  function automatic logic [STICK_W-1:0] mag8(input logic [STICK_W-1:0] n);
    return n[STICK_W-1] ? STICK_W'(~n + STICK_W'(1)) : n;
  endfunction

  // sign-preserving shaped value
  function automatic logic signed [CURVE_W-1:0] shape(input logic sgn,
                                                      input logic [CURVE_MAG_W-1:0] mag);
    logic signed [CURVE_W-1:0] pos;
    pos = $signed({1'b0, mag});
    return sgn ? -pos : pos;
  endfunction

  // table address: idx = r * DEPTH >> 14, mirrored in odd quadrants
  always_comb begin
    quad_s = heading[HEAD_W-1 -: 2];
    quad_c = quad_s + 2'd1;
    iprod  = IPROD_W'(heading[QUAD_R_W-1:0]) * IPROD_W'(TRIG_TABLE_DEPTH);
    idx    = iprod[IPROD_W-1:QUAD_R_W];

    front_nxt.valid = accept;
    front_nxt.x     = shape(stick_x[STICK_W-1], curve_lut[mag8(stick_x)]);
    front_nxt.y     = shape(stick_y[STICK_W-1], curve_lut[mag8(stick_y)]);
    front_nxt.turn  = shape(stick_turn[STICK_W-1], curve_lut[mag8(stick_turn)]);
    front_nxt.idx_s = quad_s[0] ? IDX_W'(TRIG_TABLE_DEPTH) - idx : idx;
    front_nxt.idx_c = quad_c[0] ? IDX_W'(TRIG_TABLE_DEPTH) - idx : idx;
    front_nxt.neg_s = quad_s[1];
    front_nxt.neg_c = quad_c[1];
  end

  // stage register; only valid is reset
  always_ff @(posedge clk) begin
    front_r.x     <= front_nxt.x;
    front_r.y     <= front_nxt.y;
    front_r.turn  <= front_nxt.turn;
    front_r.idx_s <= front_nxt.idx_s;
    front_r.idx_c <= front_nxt.idx_c;
    front_r.neg_s <= front_nxt.neg_s;
    front_r.neg_c <= front_nxt.neg_c;
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else begin
      front_r.valid <= front_nxt.valid;
    end
  end

  assign front_o = front_r;

endmodule

[design/cfdm_trig_rom.sv]
// ----------------------------------------------------------------------------
// cfdm_trig_rom
// Quarter-wave sine table in Q(TRIG_FRAC_BITS) with registered read; the
// quadrant sign is applied on the way into the output register.
// ----------------------------------------------------------------------------
module cfdm_trig_rom import cfdm_pkg::*; (
  input  logic                      clk,
  input  logic [IDX_W-1:0]          addr,
  input  logic                      neg,
  output logic signed [TRIG_W-1:0]  sample_r
);

  logic [TRIG_MAG_W-1:0] trig_lut [TRIG_TABLE_DEPTH + 1];

  for (genvar i = 0; i <= TRIG_TABLE_DEPTH; i++) begin : g_trig
    localparam logic [TRIG_MAG_W-1:0] TRIG_VAL = quarter_sine(i);
    assign trig_lut[i] = TRIG_VAL;
  end

  logic signed [TRIG_W-1:0] mag;
  logic signed [TRIG_W-1:0] sample_nxt;

  always_comb begin
    mag        = $signed({1'b0, trig_lut[addr]});
    sample_nxt = neg ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
  end

endmodule

[design/cfdm_mix.sv]
// ----------------------------------------------------------------------------
// cfdm_mix
// Rotation and rail mixing: one multiply layer, one add layer, then
// saturation to +-127 and truncation toward zero.
// ----------------------------------------------------------------------------
module cfdm_mix import cfdm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  input  logic signed [CURVE_W-1:0]  x_i,
  input  logic signed [CURVE_W-1:0]  y_i,
  input  logic signed [CURVE_W-1:0]  turn_i,
  input  logic signed [TRIG_W-1:0]   sin_i,
  input  logic signed [TRIG_W-1:0]   cos_i,
  output cfdm_cmd_t                  cmd_o
);

  localparam logic signed [SUM_W-1:0] LIM_Q   = SUM_W'(CMD_LIMIT * (2 ** TRIG_FRAC_BITS));
  localparam logic signed [SUM_W-1:0] ROUND_Q = SUM_W'((2 ** TRIG_FRAC_BITS) - 1);

  // multiply stage
  logic                      mul_valid_r;
  logic signed [PROD_W-1:0]  xc_r, ys_r, xs_r, yc_r;
  logic signed [SUM_W-1:0]   tq_r;

  // add stage
  logic                      add_valid_r;
  logic signed [SUM_W-1:0]   dy;
  logic signed [SUM_W-1:0]   left_r, right_r, strafe_r;

  cfdm_cmd_t cmd_r, cmd_nxt;

  // clamp to +-127 in Q(F), then divide by 2^F toward zero
  function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    logic signed [SUM_W-1:0] q;
    c = v;
    if (c > LIM_Q)  c = LIM_Q;
    if (c < -LIM_Q) c = -LIM_Q;
    if (c < 0)      c = c + ROUND_Q;
    q = c >>> TRIG_FRAC_BITS;
    return q[CMD_W-1:0];
  endfunction

  // products and scaled turn term
  always_ff @(posedge clk) begin
    xc_r <= x_i * cos_i;
    ys_r <= y_i * sin_i;
    xs_r <= x_i * sin_i;
    yc_r <= y_i * cos_i;
    tq_r <= SUM_W'(turn_i) <<< TRIG_FRAC_BITS;
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= valid_i;
    end
  end

  // rotated pair and rail sums
  assign dy = SUM_W'(xs_r) + SUM_W'(yc_r);

  always_ff @(posedge clk) begin
    strafe_r <= SUM_W'(xc_r) - SUM_W'(ys_r);
    left_r   <= dy + tq_r;
    right_r  <= dy - tq_r;
    if (!rst_n) begin
      add_valid_r <= 1'b0;
    end else begin
      add_valid_r <= mul_valid_r;
    end
  end

  // saturate into the result register
  always_comb begin
    cmd_nxt.valid  = add_valid_r;
    cmd_nxt.left   = sat_cmd(left_r);
    cmd_nxt.right  = sat_cmd(right_r);
    cmd_nxt.strafe = sat_cmd(strafe_r);
  end

  always_ff @(posedge clk) begin
    cmd_r.left   <= cmd_nxt.left;
    cmd_r.right  <= cmd_nxt.right;
    cmd_r.strafe <= cmd_nxt.strafe;
    if (!rst_n) begin
      cmd_r.valid <= 1'b0;
    end else begin
      cmd_r.valid <= cmd_nxt.valid;
    end
  end

  assign cmd_o = cmd_r;

endmodule

[design/field_centric_drive_mixer_top.sv]
// ----------------------------------------------------------------------------
// field_centric_drive_mixer_top
// Field-centric H-drive mixer: curve-shaped sticks, heading rotation of the
// translation pair, rail mixing and saturation, in a five-stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel   handshake          ports
//  -------   ----------------   ---------------------------------------------
//  input     start / busy       in_stick_x, in_stick_y, in_stick_turn, in_heading
//  result    out_valid strobe   out_left_drive, out_right_drive, out_strafe_drive
//
//  A word is taken on every clock where start is high; busy stays low.
//  Each word gives one result, in order, after passing the five register
//  stages: curve/address, trig table read, multiply, add, saturate.
//  Synchronous active-low reset clears the valid bits; nothing else is reset.
//  The result side has no back-pressure, so the pipeline never stalls.
// ----------------------------------------------------------------------------
`include "field_centric_drive_mixer_top_macros.svh"

module field_centric_drive_mixer_top import cfdm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [STICK_W-1:0] in_stick_x,
  input  logic signed [STICK_W-1:0] in_stick_y,
  input  logic signed [STICK_W-1:0] in_stick_turn,
  input  logic [HEAD_W-1:0]         in_heading,
  output logic                      out_valid,
  output logic signed [CMD_W-1:0]   out_left_drive,
  output logic signed [CMD_W-1:0]   out_right_drive,
  output logic signed [CMD_W-1:0]   out_strafe_drive
);

  logic         accept;
  cfdm_front_t  front;
  cfdm_cmd_t    cmd;

  // trig read stage: shaped sticks travel alongside the table reads
  logic                      rd_valid_r;
  logic signed [CURVE_W-1:0] rd_x_r, rd_y_r, rd_turn_r;
  logic signed [TRIG_W-1:0]  sin_r, cos_r;

  // never back-pressured: one word per cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  cfdm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .stick_x    (in_stick_x),
    .stick_y    (in_stick_y),
    .stick_turn (in_stick_turn),
    .heading    (in_heading),
    .front_o    (front)
  );

  cfdm_trig_rom u_sin_rom (
    .clk      (clk),
    .addr     (front.idx_s),
    .neg      (front.neg_s),
    .sample_r (sin_r)
  );

  cfdm_trig_rom u_cos_rom (
    .clk      (clk),
    .addr     (front.idx_c),
    .neg      (front.neg_c),
    .sample_r (cos_r)
  );

  always_ff @(posedge clk) begin
    rd_x_r    <= front.x;
    rd_y_r    <= front.y;
    rd_turn_r <= front.turn;
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= front.valid;
    end
  end

  cfdm_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (rd_valid_r),
    .x_i     (rd_x_r),
    .y_i     (rd_y_r),
    .turn_i  (rd_turn_r),
    .sin_i   (sin_r),
    .cos_i   (cos_r),
    .cmd_o   (cmd)
  );

  assign out_valid        = cmd.valid;
  assign out_left_drive   = cmd.left;
  assign out_right_drive  = cmd.right;
  assign out_strafe_drive = cmd.strafe;

  // every accepted word comes out after the five stages
  `CFDM_ASSERT_AFTER(a_latency, 5, accept, out_valid)

  // saturation never lets -128 through
  `CFDM_ASSERT_IMPLY(a_cmd_range, out_valid,
    out_left_drive != 8'sh80 && out_right_drive != 8'sh80 && out_strafe_drive != 8'sh80)

  // centered sticks give a stopped chassis at any heading
  `CFDM_ASSERT_AFTER(a_zero_sticks, 5,
    accept && in_stick_x == 8'sd0 && in_stick_y == 8'sd0 && in_stick_turn == 8'sd0,
    out_left_drive == 8'sd0 && out_right_drive == 8'sd0 && out_strafe_drive == 8'sd0)

endmodule
